[design/assert_macros.svh]
// concurrent assertion helpers, clocked on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

[design/ptsc_pkg.sv]
package ptsc_pkg;

    localparam int DELAY_W = 20;

    localparam logic [DELAY_W-1:0] GUARD_MAX   = {DELAY_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd1000;

    typedef struct packed {
        logic in_level;
        logic off_level;
        logic lock_request;
        logic alarm_not_ack;
    } in_item_t;

    typedef struct packed {
        logic out_state;
        logic alarm_flag;
        logic locked_flag;
    } out_item_t;

endpackage

[design/ptsc_in_if.sv]
interface ptsc_in_if;
    logic                valid;
    logic                ready;
    ptsc_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/ptsc_out_if.sv]
interface ptsc_out_if;
    logic                valid;
    logic                ready;
    ptsc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/protected_toggle_switch_controller.sv]
// Protected toggle switch: each accepted tick item (toggle level, off level,
// lock request, alarm-not-acknowledged) produces exactly one result item with
// the switched output, the alarm and the lock of that tick. A rising toggle
// edge inverts the output, a rising off edge while on switches it off, a
// toggle closer than switch_delay ticks to the last change is refused,
// raising the alarm and restarting the guard, and an early off request is
// held until the guard passes. One item is taken every cycle while the input
// is not stalled; an accepted item waits in the input register and is worked
// into the result register, from which its result is offered, once that
// register is free or being taken. A full result register stalls the input
// only once the input register also holds an item.
// switch_delay resets to 1000; the user writes it through cfg_we/cfg_wdata
// only while no item is in flight, which the block does not enforce.
module protected_toggle_switch_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptsc_pkg::DELAY_W-1:0]  cfg_wdata,
    ptsc_in_if.sink                       tick,
    ptsc_out_if.source                    result
);

    logic [ptsc_pkg::DELAY_W-1:0] switch_delay_reg;
    logic                         in_valid_reg;
    ptsc_pkg::in_item_t           in_data_reg;
    logic                         out_valid_reg;
    ptsc_pkg::out_item_t          out_data_reg;
    ptsc_pkg::out_item_t          step_result;
    logic                         advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_delay_reg <= ptsc_pkg::DELAY_RESET;
        end
        else if (cfg_we)
        begin
            switch_delay_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            in_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_data_reg <= tick.data;
        end
    end

    ptsc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (advance),
        .item         (in_data_reg),
        .switch_delay (switch_delay_reg),
        .result       (step_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

endmodule

[design/ptsc_core.sv]
`include "assert_macros.svh"

module ptsc_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  ptsc_pkg::in_item_t              item,
    input  logic [ptsc_pkg::DELAY_W-1:0]    switch_delay,
    output ptsc_pkg::out_item_t             result
);

    logic                         input_prev_reg, input_prev_next;
    logic                         off_prev_reg, off_prev_next;
    logic                         trigger_pending_reg, trigger_pending_next;
    logic                         off_pending_reg, off_pending_next;
    logic                         output_on_reg, output_on_next;
    logic                         alarm_active_reg, alarm_active_next;
    logic                         guard_running_reg, guard_running_next;
    logic [ptsc_pkg::DELAY_W-1:0] guard_count_reg, guard_count_next;

    logic [ptsc_pkg::DELAY_W-1:0] count_tick;
    logic                         passed;
    logic                         trig;
    logic                         offp;
    logic                         lock_base;
    logic                         lock_final;
    logic                         do_toggle;
    logic                         do_off;

    always_comb
    begin
        count_tick = guard_count_reg;
        if (guard_running_reg && (guard_count_reg != ptsc_pkg::GUARD_MAX))
        begin
            count_tick = guard_count_reg + 1'b1;
        end
        passed = !guard_running_reg || (count_tick >= switch_delay);

        trig = trigger_pending_reg || (item.in_level && !input_prev_reg);
        offp = off_pending_reg ||
               (output_on_reg && item.off_level && !off_prev_reg);

        lock_base = alarm_active_reg || item.alarm_not_ack || item.lock_request ||
                    (offp && !passed);

        do_toggle = trig && !lock_base && !offp;
        do_off    = offp && !lock_base;

        output_on_next       = output_on_reg;
        alarm_active_next    = alarm_active_reg && !(item.alarm_not_ack && passed);
        lock_final           = lock_base;
        guard_running_next   = guard_running_reg;
        guard_count_next     = count_tick;
        trigger_pending_next = trig && !lock_base && offp;
        off_pending_next     = offp && lock_base;

        if (do_toggle)
        begin
            if (passed)
            begin
                output_on_next = !output_on_reg;
            end
            else
            begin
                alarm_active_next = 1'b1;
                lock_final        = 1'b1;
            end
        end

        if (do_off)
        begin
            output_on_next = 1'b0;
        end

        if (do_toggle || do_off)
        begin
            guard_running_next = 1'b1;
            guard_count_next   = '0;
        end

        input_prev_next = item.in_level;
        off_prev_next   = item.off_level;

        result.out_state   = output_on_next;
        result.alarm_flag  = alarm_active_next;
        result.locked_flag = lock_final;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_prev_reg      <= 1'b0;
            off_prev_reg        <= 1'b0;
            trigger_pending_reg <= 1'b0;
            off_pending_reg     <= 1'b0;
            output_on_reg       <= 1'b0;
            alarm_active_reg    <= 1'b0;
            guard_running_reg   <= 1'b0;
            guard_count_reg     <= '0;
        end
        else if (step_en)
        begin
            input_prev_reg      <= input_prev_next;
            off_prev_reg        <= off_prev_next;
            trigger_pending_reg <= trigger_pending_next;
            off_pending_reg     <= off_pending_next;
            output_on_reg       <= output_on_next;
            alarm_active_reg    <= alarm_active_next;
            guard_running_reg   <= guard_running_next;
            guard_count_reg     <= guard_count_next;
        end
    end

    // state moves only with an item
    `ASSERT_CLK(a_out_only_on_step, !step_en |=> $stable(output_on_reg) && $stable(guard_count_reg))
    // an output change needs the guard to have passed
    `ASSERT_NEVER(a_change_needs_guard, step_en && (output_on_next != output_on_reg) && !passed)
    // a raised alarm comes from a locked item
    `ASSERT_CLK(a_alarm_rise_locked, $rose(alarm_active_reg) |-> $past(step_en) && $past(lock_final))
    // an idle guard keeps its count at zero
    `ASSERT_NEVER(a_idle_guard_zero, !guard_running_reg && (guard_count_reg != '0))

endmodule

[dv/tb_protected_toggle_switch_controller.sv]
`timescale 1ns / 100ps

module tb_protected_toggle_switch_controller;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit                               in_prev;
        bit                               off_prev;
        bit                               toggle_wait;
        bit                               off_wait;
        bit                               on;
        bit                               alarm;
        bit                               guard_run;
        bit [ptsc_pkg::DELAY_W-1:0]       guard_cnt;
    } switch_state_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [ptsc_pkg::DELAY_W-1:0] cfg_wdata;

    ptsc_in_if  tick_if ();
    ptsc_out_if res_if ();

    protected_toggle_switch_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .tick      (tick_if),
        .result    (res_if)
    );

    switch_state_t                sw;
    bit [ptsc_pkg::DELAY_W-1:0]   delay_cfg = ptsc_pkg::DELAY_RESET;
    bit                           lv_in;
    bit                           lv_off;

    ptsc_pkg::in_item_t           pending_ticks[$];
    ptsc_pkg::out_item_t          expected_results[$];
    ptsc_pkg::out_item_t          want;

    int                 n_pushed;
    int                 n_accepted;
    int                 n_results;
    int                 n_errors;
    int                 n_settings;
    int                 n_cycles;
    int                 n_holds;
    int                 send_gap;
    int                 send_burst;
    int                 stall_left;
    int                 flow_left;
    int                 hold_left;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic bit guard_ok();
        return !sw.guard_run || sw.guard_cnt >= delay_cfg;
    endfunction

    // a change that comes too early is refused, but the guard restarts either way
    function automatic void switch_output(bit value, inout bit locked);
        if (guard_ok())
        begin
            sw.on = value;
        end
        else
        begin
            sw.alarm = 1'b1;
            locked = 1'b1;
        end
        sw.guard_run = 1'b1;
        sw.guard_cnt = '0;
    endfunction

    function automatic ptsc_pkg::out_item_t step_switch(ptsc_pkg::in_item_t it);
        ptsc_pkg::out_item_t r;
        bit                  locked;
        if (sw.guard_run && sw.guard_cnt != ptsc_pkg::GUARD_MAX)
            sw.guard_cnt++;
        if (it.in_level && !sw.in_prev)
            sw.toggle_wait = 1'b1;
        sw.in_prev = it.in_level;
        if (sw.on && it.off_level && !sw.off_prev)
            sw.off_wait = 1'b1;
        sw.off_prev = it.off_level;
        locked = sw.alarm || it.alarm_not_ack || it.lock_request
                 || (sw.off_wait && !guard_ok());
        if (sw.alarm && it.alarm_not_ack && guard_ok())
            sw.alarm = 1'b0;
        if (locked)
            sw.toggle_wait = 1'b0;
        if (sw.toggle_wait && !sw.off_wait)
        begin
            sw.toggle_wait = 1'b0;
            switch_output(!sw.on, locked);
        end
        if (sw.off_wait && !locked)
        begin
            switch_output(1'b0, locked);
            sw.off_wait = 1'b0;
        end
        r.out_state = sw.on;
        r.alarm_flag = sw.alarm;
        r.locked_flag = locked;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // levels held over runs of items so edges come at varied spacing
    function automatic ptsc_pkg::in_item_t rand_tick();
        ptsc_pkg::in_item_t t;
        if ($urandom_range(0, 9) == 0)
        begin
            t = 4'($urandom_range(0, 15));
            return t;
        end
        if ($urandom_range(0, 2) == 0)
            lv_in = !lv_in;
        if ($urandom_range(0, 3) == 0)
            lv_off = !lv_off;
        t.in_level = lv_in;
        t.off_level = lv_off;
        t.lock_request = ($urandom_range(0, 7) == 0);
        t.alarm_not_ack = ($urandom_range(0, 7) == 0);
        return t;
    endfunction

    function automatic void push_tick(ptsc_pkg::in_item_t t);
        pending_ticks.push_back(t);
        n_pushed++;
    endfunction

    task automatic settle();
        while (n_accepted != n_pushed || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_delay(input logic [ptsc_pkg::DELAY_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        delay_cfg = value;
        n_settings++;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_if.valid <= 1'b0;
            tick_if.data <= '0;
        end
        else
        begin
            if (tick_if.valid && tick_if.ready)
            begin
                expected_results.push_back(step_switch(tick_if.data));
                n_accepted++;
            end
            if (!tick_if.valid || tick_if.ready)
            begin
                if (send_gap > 0)
                begin
                    tick_if.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_ticks.size() != 0)
                begin
                    tick_if.valid <= 1'b1;
                    tick_if.data <= pending_ticks.pop_front();
                    if (send_burst > 0)
                        send_burst--;
                    else if ($urandom_range(0, 99) < 50)
                        send_gap = 0;
                    else if ($urandom_range(0, 99) < 15)
                        send_burst = $urandom_range(20, 60);
                    else
                        send_gap = pick_gap();
                end
                else
                begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_if.data.out_state !== want.out_state)
                    begin
                        $error("out_state: expected %0b, got %0b",
                               want.out_state, res_if.data.out_state);
                        n_errors++;
                    end
                    if (res_if.data.alarm_flag !== want.alarm_flag)
                    begin
                        $error("alarm_flag: expected %0b, got %0b",
                               want.alarm_flag, res_if.data.alarm_flag);
                        n_errors++;
                    end
                    if (res_if.data.locked_flag !== want.locked_flag)
                    begin
                        $error("locked_flag: expected %0b, got %0b",
                               want.locked_flag, res_if.data.locked_flag);
                        n_errors++;
                    end
                end
                // long hold-off so the block backs up and stalls its input
                if (n_results == 300 || n_results == 900)
                begin
                    hold_left = 300;
                    n_holds++;
                end
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (flow_left > 0)
            begin
                res_if.ready <= 1'b1;
                flow_left--;
            end
            else if ($urandom_range(0, 99) < 60)
            begin
                res_if.ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < 20)
            begin
                res_if.ready <= 1'b1;
                flow_left = $urandom_range(20, 60);
            end
            else
            begin
                res_if.ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("protected_toggle_switch_controller: mismatch");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_delay[4];
        int          phase_items[4];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        tick_if.valid = 1'b0;
        tick_if.data = '0;
        res_if.ready = 1'b0;
        phase_delay = '{1, $urandom_range(2, 6), 0, $urandom_range(7, 30)};
        phase_items = '{350, 350, 300, 400};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset delay: accepted toggle, early toggle refused, ack before guard passes
        push_tick(4'b0000);
        push_tick(4'b1000);
        push_tick(4'b0000);
        push_tick(4'b1000);
        push_tick(4'b0000);
        push_tick(4'b0001);
        push_tick(4'b1111);
        settle();

        // zero delay, off request held by lock, toggle held behind off request
        write_delay('0);
        push_tick(4'b0001);
        push_tick(4'b0000);
        push_tick(4'b1000);
        push_tick(4'b0110);
        push_tick(4'b0100);
        push_tick(4'b0000);
        push_tick(4'b1000);
        push_tick(4'b0000);
        push_tick(4'b1100);
        push_tick(4'b1100);
        push_tick(4'b0000);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            write_delay(ptsc_pkg::DELAY_W'(phase_delay[p]));
            repeat (phase_items[p]) push_tick(rand_tick());
            settle();
        end

        // largest delay, so every toggle is refused and every off request is held
        write_delay(ptsc_pkg::GUARD_MAX);
        repeat (60) push_tick(rand_tick());
        settle();

        write_delay(ptsc_pkg::DELAY_W'(3));
        repeat (240) push_tick(rand_tick());
        settle();
        repeat (4) @(posedge clk);

        $display("%0d tick items under %0d switch_delay settings, %0d results checked",
                 n_accepted, n_settings + 1, n_results);
        $display("%0d long receiver hold-offs while the sender kept offering items", n_holds);
        if (n_errors == 0)
            $display("protected_toggle_switch_controller: match");
        else
            $display("protected_toggle_switch_controller: mismatch");
        $finish;
    end

endmodule
